// File: src/drwc_pkg.sv
package drwc_pkg;

   localparam int CODE_BITS = 12;
   localparam int REG_W     = 16;
   localparam int MV_W      = 16;
   localparam int OHM_W     = 16;
   localparam int REF_W     = 9;
   localparam int PROD_W    = CODE_BITS + REG_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int NUM_W     = MV_W + REF_W;
   localparam int LIM_W     = MV_W + OHM_W;
   localparam int CSR_IDX_W = 3;

   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES          = OHM_W / DIV_STEPS_PER_STAGE;
   localparam int FRONT_STAGES        = 7;
   localparam int VLD_DEPTH           = FRONT_STAGES + DIV_STAGES;
   localparam int RSP_LATENCY         = VLD_DEPTH + 1;

   localparam logic [PROD_W-1:0] FULL_CODE  = PROD_W'((1 << CODE_BITS) - 1);
   localparam logic [MV_W-1:0]   NO_LOAD_MV = MV_W'(90);
   localparam logic [REF_W-1:0]  REF_OHMS   = REF_W'(510);
   localparam logic [OHM_W-1:0]  OHMS_MAX   = '1;

   localparam logic [REG_W-1:0] FULL_SCALE_RST = REG_W'(5000);
   localparam logic [REG_W-1:0] LOW_LIMIT_RST  = '0;
   localparam logic [REG_W-1:0] HIGH_LIMIT_RST = '1;

   typedef enum logic [1:0] {
      VERDICT_PASS      = 2'd0,
      VERDICT_TEMP_FAIL = 2'd1,
      VERDICT_HEAT_FAIL = 2'd2,
      VERDICT_NO_LOAD   = 2'd3
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_SCALE_MV   = 3'd0,
      CSR_TEMP_LOW_LIMIT  = 3'd1,
      CSR_TEMP_HIGH_LIMIT = 3'd2,
      CSR_HEAT_LOW_LIMIT  = 3'd3,
      CSR_HEAT_HIGH_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] temp_top_code;
      logic [CODE_BITS-1:0] temp_bottom_code;
      logic [CODE_BITS-1:0] heat_top_code;
      logic [CODE_BITS-1:0] heat_bottom_code;
   } req_item_type;

   typedef struct packed {
      verdict_type        verdict;
      logic [OHM_W-1:0]   temp_ohms;
      logic [OHM_W-1:0]   heat_ohms;
   } rsp_item_type;

endpackage

// File: src/divider_resistance_window_check_top.sv
// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+----------------------------------
// item in   | start, busy, req_item               | taken when start high, busy low
// result    | rsp_valid, rsp_item                 | one-cycle strobe, cannot be held
// registers | csr_we, csr_index, csr_wdata        | written when csr_we high
//
// One item per cycle. Each item passes 7 front stages (multiply, /4095, subtract,
// multiply) and 8 divider stages of 2 restoring steps each.
// Synchronous reset clears the valid bits and restores the register defaults.
// busy stays low: the pipeline never stalls and the receiver cannot stall it.
module divider_resistance_window_check_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  drwc_pkg::req_item_type          req_item,
   output logic                            rsp_valid,
   output drwc_pkg::rsp_item_type          rsp_item,
   input  logic                            csr_we,
   input  logic [drwc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [drwc_pkg::REG_W-1:0]      csr_wdata
);
   import drwc_pkg::*;

   typedef struct packed {
      logic             sat;
      logic [MV_W-1:0]  bot;
      logic [MV_W-1:0]  rem;
      logic [OHM_W-1:0] num_lo;
      logic [OHM_W-1:0] quot;
   } div_type;

   logic [REG_W-1:0]     full_scale_ff;
   logic [REG_W-1:0]     temp_lo_ff;
   logic [REG_W-1:0]     temp_hi_ff;
   logic [REG_W-1:0]     heat_lo_ff;
   logic [REG_W-1:0]     heat_hi_ff;
   logic [VLD_DEPTH-1:0] vld_ff;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_ff;
   rsp_item_type         rsp_in;

   logic [CODE_BITS-1:0] code_in [4];
   logic [PROD_W-1:0]    prod_ff [4];
   logic [PROD_W-1:0]    prod_in [4];
   logic [PROD_W-1:0]    x2_ff   [4];
   logic [MV_W-1:0]      q1_ff   [4];
   logic [MV_W-1:0]      q1_in   [4];
   logic [MV_W-1:0]      q1b_ff  [4];
   logic [CODE_BITS:0]   rem_ff  [4];
   logic [CODE_BITS:0]   rem_in  [4];
   logic [MV_W-1:0]      mv_ff   [4];
   logic [MV_W-1:0]      mv_in   [4];

   logic                 noload5_ff;
   logic                 noload5_in;
   logic [MV_W-1:0]      diff_ff [2];
   logic [MV_W-1:0]      diff_in [2];
   logic [MV_W-1:0]      bot5_ff [2];
   logic                 noload6_ff;
   logic [NUM_W-1:0]     num_ff  [2];
   logic [NUM_W-1:0]     num_in  [2];
   logic [MV_W-1:0]      bot6_ff [2];

   div_type              div_ff [DIV_STAGES+1][2];
   div_type              div_in [DIV_STAGES+1][2];
   logic                 nl_ff  [DIV_STAGES+1];

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign code_in[0] = req_item.temp_top_code;
   assign code_in[1] = req_item.temp_bottom_code;
   assign code_in[2] = req_item.heat_top_code;
   assign code_in[3] = req_item.heat_bottom_code;

   // code * full scale, then /4095 by reciprocal series and one correction
   always_comb begin
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] back;
      logic [PROD_W-1:0] r;
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = PROD_W'(code_in[i]) * PROD_W'(full_scale_ff);
         sum = SUM_W'(prod_ff[i]) + SUM_W'(prod_ff[i] >> CODE_BITS)
             + SUM_W'(prod_ff[i] >> (2 * CODE_BITS)) + SUM_W'(prod_ff[i] >> (3 * CODE_BITS));
         q1_in[i] = MV_W'(sum >> CODE_BITS);
         back = (PROD_W'(q1_ff[i]) << CODE_BITS) - PROD_W'(q1_ff[i]);
         r = x2_ff[i] - back;
         rem_in[i] = r[CODE_BITS:0];
         mv_in[i] = q1b_ff[i] + MV_W'(rem_ff[i] >= FULL_CODE[CODE_BITS:0]);
      end
   end

   always_comb begin
      noload5_in = (mv_ff[1] < NO_LOAD_MV) || (mv_ff[3] < NO_LOAD_MV);
      for (int l = 0; l < 2; l++) begin
         diff_in[l] = (mv_ff[2*l] > mv_ff[2*l+1]) ? mv_ff[2*l] - mv_ff[2*l+1] : '0;
         num_in[l]  = NUM_W'(diff_ff[l]) * NUM_W'(REF_OHMS);
      end
   end

   // restoring division, quotient bits from the top
   always_comb begin
      div_type           st;
      logic [MV_W:0]     sh;
      for (int l = 0; l < 2; l++) begin
         div_in[0][l].sat    = LIM_W'(num_ff[l]) >= {bot6_ff[l], OHM_W'(0)};
         div_in[0][l].bot    = bot6_ff[l];
         div_in[0][l].rem    = MV_W'(num_ff[l] >> OHM_W);
         div_in[0][l].num_lo = num_ff[l][OHM_W-1:0];
         div_in[0][l].quot   = '0;
      end
      for (int j = 0; j < DIV_STAGES; j++) begin
         for (int l = 0; l < 2; l++) begin
            st = div_ff[j][l];
            for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
               sh = {st.rem, st.num_lo[OHM_W-1-j*DIV_STEPS_PER_STAGE-k]};
               if (sh >= {1'b0, st.bot}) begin
                  sh = sh - {1'b0, st.bot};
                  st.quot[OHM_W-1-j*DIV_STEPS_PER_STAGE-k] = 1'b1;
               end
               st.rem = sh[MV_W-1:0];
            end
            div_in[j+1][l] = st;
         end
      end
   end

   always_comb begin
      logic [OHM_W-1:0] ohms [2];
      for (int l = 0; l < 2; l++) begin
         if (nl_ff[DIV_STAGES]) begin
            ohms[l] = '0;
         end else if (div_ff[DIV_STAGES][l].sat) begin
            ohms[l] = OHMS_MAX;
         end else begin
            ohms[l] = div_ff[DIV_STAGES][l].quot;
         end
      end
      if (nl_ff[DIV_STAGES]) begin
         rsp_in.verdict = VERDICT_NO_LOAD;
      end else if (!(ohms[0] > temp_lo_ff && ohms[0] < temp_hi_ff)) begin
         rsp_in.verdict = VERDICT_TEMP_FAIL;
      end else if (!(ohms[1] > heat_lo_ff && ohms[1] < heat_hi_ff)) begin
         rsp_in.verdict = VERDICT_HEAT_FAIL;
      end else begin
         rsp_in.verdict = VERDICT_PASS;
      end
      rsp_in.temp_ohms = ohms[0];
      rsp_in.heat_ohms = ohms[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         full_scale_ff <= FULL_SCALE_RST;
         temp_lo_ff    <= LOW_LIMIT_RST;
         temp_hi_ff    <= HIGH_LIMIT_RST;
         heat_lo_ff    <= LOW_LIMIT_RST;
         heat_hi_ff    <= HIGH_LIMIT_RST;
      end else begin
         vld_ff       <= {vld_ff[VLD_DEPTH-2:0], start && !busy};
         rsp_valid_ff <= vld_ff[VLD_DEPTH-1];
         if (csr_we) begin
            case (csr_index)
               CSR_FULL_SCALE_MV:   full_scale_ff <= csr_wdata;
               CSR_TEMP_LOW_LIMIT:  temp_lo_ff    <= csr_wdata;
               CSR_TEMP_HIGH_LIMIT: temp_hi_ff    <= csr_wdata;
               CSR_HEAT_LOW_LIMIT:  heat_lo_ff    <= csr_wdata;
               CSR_HEAT_HIGH_LIMIT: heat_hi_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         prod_ff[i] <= prod_in[i];
         x2_ff[i]   <= prod_ff[i];
         q1_ff[i]   <= q1_in[i];
         q1b_ff[i]  <= q1_ff[i];
         rem_ff[i]  <= rem_in[i];
         mv_ff[i]   <= mv_in[i];
      end
      noload5_ff <= noload5_in;
      noload6_ff <= noload5_ff;
      nl_ff[0]   <= noload6_ff;
      for (int l = 0; l < 2; l++) begin
         diff_ff[l]   <= diff_in[l];
         bot5_ff[l]   <= mv_ff[2*l+1];
         num_ff[l]    <= num_in[l];
         bot6_ff[l]   <= bot5_ff[l];
         div_ff[0][l] <= div_in[0][l];
      end
      for (int j = 1; j <= DIV_STAGES; j++) begin
         nl_ff[j] <= nl_ff[j-1];
         for (int l = 0; l < 2; l++) begin
            div_ff[j][l] <= div_in[j][l];
         end
      end
      rsp_ff <= rsp_in;
   end

endmodule

// File: src/drwc_checker.sv
module drwc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input drwc_pkg::rsp_item_type rsp_item
);
   import drwc_pkg::*;

   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("item taken without result at fixed latency");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without matching item");

   a_no_load_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.verdict == VERDICT_NO_LOAD)
         |-> (rsp_item.temp_ohms == '0 && rsp_item.heat_ohms == '0))
      else $error("no-load result with nonzero resistance");

   a_pass_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.verdict == VERDICT_PASS)
         |-> (rsp_item.temp_ohms != '0 && rsp_item.temp_ohms != OHMS_MAX
              && rsp_item.heat_ohms != '0 && rsp_item.heat_ohms != OHMS_MAX))
      else $error("pass with resistance on a window edge");

endmodule

bind divider_resistance_window_check_top drwc_checker u_drwc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
